### rtl/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

    localparam logic [2:0] FN_TICK  = 3'd0;
    localparam logic [2:0] FN_START = 3'd1;
    localparam logic [2:0] FN_STOP  = 3'd2;
    localparam logic [2:0] FN_WRITE = 3'd3;
    localparam logic [2:0] FN_ACK   = 3'd4;
    localparam logic [2:0] FN_READ  = 3'd5;

    localparam logic [0:0] REG_TICKS_PER_US   = 1'd0;
    localparam logic [0:0] REG_ACK_POLL_LIMIT = 1'd1;

    localparam logic [7:0] TICKS_PER_US_RST   = 8'd1;
    localparam logic [7:0] ACK_POLL_LIMIT_RST = 8'd250;

    typedef enum logic [3:0] {
        PH_START_A     = 4'd0,
        PH_START_B     = 4'd1,
        PH_BIT_SET     = 4'd2,
        PH_BIT_HIGH    = 4'd3,
        PH_BIT_LOW     = 4'd4,
        PH_ACK_REL     = 4'd5,
        PH_ACK_HIGH    = 4'd6,
        PH_ACK_POLL    = 4'd7,
        PH_STOP_A      = 4'd8,
        PH_STOP_B      = 4'd9,
        PH_RD_LOW      = 4'd10,
        PH_RD_HIGH     = 4'd11,
        PH_RD_ACK_SET  = 4'd12,
        PH_RD_ACK_HIGH = 4'd13
    } t_phase;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic       ack_error;
        logic [7:0] rx_byte;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/i2c_bitbang_master.sv
// Channel  Direction  Handshake                     Payload
// in       input      i_in_valid / o_in_stall       i_in_data  (t_in_item)
// out      output     o_out_valid / i_out_stall     o_out_data (t_out_item)
// cfg      input      i_cfg_we                      i_cfg_idx, i_cfg_data
//
// One transaction in gives one transaction out; one tick is taken per cycle while the input is not stalled.
// Bus state is computed combinationally into the result register, so the result
// follows in the cycle after acceptance.
// Synchronous active-low reset: bus lines high, SDA driven, engine idle.
// Input stalls only while a result waits and the output is stalled.
`default_nettype none

module i2c_bitbang_master
    import i2cm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_item   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_item       o_out_data,
    input  wire logic       i_cfg_we,
    input  wire logic [0:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);

    logic [7:0] r_ticks_per_us;
    logic [7:0] r_ack_poll_limit;
    logic       r_out_valid;
    t_out_item  r_out_data;
    t_out_item  res;
    logic       in_acc;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_acc      = i_in_valid & !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    i2cm_engine u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (in_acc),
        .i_item           (i_in_data),
        .i_ticks_per_us   (r_ticks_per_us),
        .i_ack_poll_limit (r_ack_poll_limit),
        .o_res            (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_us   <= TICKS_PER_US_RST;
            r_ack_poll_limit <= ACK_POLL_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TICKS_PER_US:   r_ticks_per_us   <= i_cfg_data;
                REG_ACK_POLL_LIMIT: r_ack_poll_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_data <= res;
        end
    end

endmodule

`default_nettype wire

### rtl/i2cm_engine.sv
`default_nettype none

module i2cm_engine
    import i2cm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire t_in_item   i_item,
    input  wire logic [7:0] i_ticks_per_us,
    input  wire logic [7:0] i_ack_poll_limit,
    output t_out_item       o_res
);

    logic [2:0] r_cmd,   n_cmd;
    t_phase     r_phase, n_phase;
    logic [3:0] r_bits,  n_bits;
    logic [9:0] r_delay, n_delay;
    logic [7:0] r_poll,  n_poll;
    logic [7:0] r_shift, n_shift;
    logic       r_scl,   n_scl;
    logic       r_sda,   n_sda;
    logic       r_dir,   n_dir;
    logic       r_ack,   n_ack;
    logic [7:0] r_rx,    n_rx;

    logic       do_enter;
    t_phase     enter_ph;
    logic       done;
    logic       err;
    logic [3:0] bits_inc;

    // delay of 1, 2 or 4 us; a zero rate gives one tick
    function automatic logic [9:0] load_delay(input logic [7:0] tpu, input logic [1:0] sh);
        logic [9:0] t;
        t = {2'b00, tpu} << sh;
        if (tpu == 8'd0) begin
            t = 10'd1;
        end
        return t;
    endfunction

    assign bits_inc = r_bits + 4'd1;

    always_comb begin
        n_cmd    = r_cmd;
        n_phase  = r_phase;
        n_bits   = r_bits;
        n_delay  = r_delay;
        n_poll   = r_poll;
        n_shift  = r_shift;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_dir    = r_dir;
        n_ack    = r_ack;
        n_rx     = r_rx;
        do_enter = 1'b0;
        enter_ph = PH_START_A;
        done     = 1'b0;
        err      = 1'b0;

        if (r_cmd == FN_TICK) begin
            if (i_item.func >= FN_START && i_item.func <= FN_READ) begin
                n_cmd    = i_item.func;
                n_poll   = 8'd0;
                n_bits   = 4'd0;
                do_enter = 1'b1;
                case (i_item.func)
                    FN_START: enter_ph = PH_START_A;
                    FN_STOP:  enter_ph = PH_STOP_A;
                    FN_WRITE: begin
                        n_shift  = i_item.tx_byte;
                        n_dir    = 1'b1;
                        n_scl    = 1'b0;
                        enter_ph = PH_BIT_SET;
                    end
                    FN_ACK:   enter_ph = PH_ACK_REL;
                    default: begin
                        n_shift  = 8'd0;
                        n_ack    = i_item.send_ack;
                        n_dir    = 1'b0;
                        enter_ph = PH_RD_LOW;
                    end
                endcase
            end
        end else if (r_delay > 10'd1) begin
            n_delay = r_delay - 10'd1;
        end else begin
            case (r_phase)
                PH_START_A:  begin do_enter = 1'b1; enter_ph = PH_START_B; end
                PH_START_B:  begin n_scl = 1'b0; done = 1'b1; end
                PH_BIT_SET:  begin do_enter = 1'b1; enter_ph = PH_BIT_HIGH; end
                PH_BIT_HIGH: begin do_enter = 1'b1; enter_ph = PH_BIT_LOW; end
                PH_BIT_LOW: begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bits  = bits_inc;
                    if (bits_inc >= 4'd8) begin
                        done = 1'b1;
                    end else begin
                        do_enter = 1'b1;
                        enter_ph = PH_BIT_SET;
                    end
                end
                PH_ACK_REL:  begin do_enter = 1'b1; enter_ph = PH_ACK_HIGH; end
                PH_ACK_HIGH: begin do_enter = 1'b1; enter_ph = PH_ACK_POLL; end
                PH_ACK_POLL: begin
                    if (!i_item.sda_in) begin
                        n_scl = 1'b0;
                        done  = 1'b1;
                    end else if (r_poll >= i_ack_poll_limit) begin
                        do_enter = 1'b1;
                        enter_ph = PH_STOP_A;
                    end else begin
                        n_poll = r_poll + 8'd1;
                    end
                end
                PH_STOP_A: begin do_enter = 1'b1; enter_ph = PH_STOP_B; end
                PH_STOP_B: begin
                    done = 1'b1;
                    err  = (r_cmd == FN_ACK);
                end
                PH_RD_LOW: begin do_enter = 1'b1; enter_ph = PH_RD_HIGH; end
                PH_RD_HIGH: begin
                    n_shift  = {r_shift[6:0], i_item.sda_in};
                    n_bits   = bits_inc;
                    do_enter = 1'b1;
                    if (bits_inc >= 4'd8) begin
                        n_rx     = {r_shift[6:0], i_item.sda_in};
                        enter_ph = PH_RD_ACK_SET;
                    end else begin
                        enter_ph = PH_RD_LOW;
                    end
                end
                PH_RD_ACK_SET:  begin do_enter = 1'b1; enter_ph = PH_RD_ACK_HIGH; end
                PH_RD_ACK_HIGH: begin n_scl = 1'b0; done = 1'b1; end
                default: done = 1'b1;
            endcase
        end

        if (done) begin
            n_cmd   = FN_TICK;
            n_phase = PH_START_A;
            n_delay = 10'd0;
        end

        if (do_enter) begin
            n_phase = enter_ph;
            case (enter_ph)
                PH_START_A: begin
                    n_dir = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                    n_delay = load_delay(i_ticks_per_us, 2'd2);
                end
                PH_START_B: begin
                    n_sda = 1'b0;
                    n_delay = load_delay(i_ticks_per_us, 2'd2);
                end
                PH_BIT_SET: begin
                    n_sda = n_shift[7];
                    n_delay = load_delay(i_ticks_per_us, 2'd1);
                end
                PH_BIT_HIGH: begin
                    n_scl = 1'b1;
                    n_delay = load_delay(i_ticks_per_us, 2'd1);
                end
                PH_BIT_LOW: begin
                    n_scl = 1'b0;
                    n_delay = load_delay(i_ticks_per_us, 2'd1);
                end
                PH_ACK_REL: begin
                    n_dir = 1'b0; n_sda = 1'b1;
                    n_delay = load_delay(i_ticks_per_us, 2'd0);
                end
                PH_ACK_HIGH: begin
                    n_scl = 1'b1;
                    n_delay = load_delay(i_ticks_per_us, 2'd0);
                end
                PH_ACK_POLL: n_delay = 10'd0;
                PH_STOP_A: begin
                    n_dir = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                    n_delay = load_delay(i_ticks_per_us, 2'd2);
                end
                PH_STOP_B: begin
                    n_scl = 1'b1; n_sda = 1'b1;
                    n_delay = load_delay(i_ticks_per_us, 2'd2);
                end
                PH_RD_LOW: begin
                    n_scl = 1'b0;
                    n_delay = load_delay(i_ticks_per_us, 2'd1);
                end
                PH_RD_HIGH: begin
                    n_scl = 1'b1;
                    n_delay = load_delay(i_ticks_per_us, 2'd0);
                end
                PH_RD_ACK_SET: begin
                    n_scl = 1'b0; n_dir = 1'b1; n_sda = !r_ack;
                    n_delay = load_delay(i_ticks_per_us, 2'd1);
                end
                PH_RD_ACK_HIGH: begin
                    n_scl = 1'b1;
                    n_delay = load_delay(i_ticks_per_us, 2'd1);
                end
                default: n_delay = 10'd1;
            endcase
        end
    end

    always_comb begin
        o_res.scl_level = n_scl;
        o_res.sda_level = n_dir ? n_sda : 1'b1;
        o_res.sda_drive = n_dir;
        o_res.busy_res  = (n_cmd != FN_TICK);
        o_res.done_res  = done;
        o_res.ack_error = err;
        o_res.rx_byte   = n_rx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd   <= FN_TICK;
            r_phase <= PH_START_A;
            r_bits  <= 4'd0;
            r_delay <= 10'd0;
            r_poll  <= 8'd0;
            r_shift <= 8'd0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_dir   <= 1'b1;
            r_ack   <= 1'b0;
            r_rx    <= 8'd0;
        end else if (i_step) begin
            r_cmd   <= n_cmd;
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_delay <= n_delay;
            r_poll  <= n_poll;
            r_shift <= n_shift;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_dir   <= n_dir;
            r_ack   <= n_ack;
            r_rx    <= n_rx;
        end
    end

endmodule

`default_nettype wire

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import i2cm_pkg::*;

    localparam logic [2:0] FN_SPARE6 = 3'd6;
    localparam logic [2:0] FN_SPARE7 = 3'd7;
    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 7;
    localparam int RUN_LIMIT_NS  = 8_000_000;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_PRINTS    = 100;
    localparam int LONG_HOLD     = 300;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_data  = '0;
    logic       out_stall = 1'b0;
    logic       cfg_we   = 1'b0;
    logic [0:0] cfg_idx  = REG_TICKS_PER_US;
    logic [7:0] cfg_data = '0;
    logic       in_stall;
    logic       out_valid;
    t_out_item  out_data;

    // engine copy used for prediction
    logic [7:0] cfg_tpu;
    logic [7:0] cfg_limit;
    logic [2:0] cur_fn;
    t_phase     cur_ph;
    logic [3:0] bit_cnt;
    logic [9:0] dly_cnt;
    logic [7:0] poll_cnt;
    logic [7:0] shifter;
    logic       scl_q;
    logic       sda_q;
    logic       sda_oe;
    logic       ack_sel;
    logic [7:0] rx_last;
    logic       tick_done;
    logic       tick_err;

    t_in_item  tick_stream[$];
    t_out_item bus_ticks_due[$];

    int plan_tpu;
    int plan_limit;
    int n_planned  = 0;
    int n_results  = 0;
    int n_mismatch = 0;
    int gap_left   = 0;
    int burst_left = 0;
    int hold_left  = 0;
    int mode_left  = 0;
    int stall_mode = 0;
    bit long_hold_done = 1'b0;

    i2c_bitbang_master dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #(CLK_HALF) clk = ~clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void reset_engine();
        cfg_tpu   = TICKS_PER_US_RST;
        cfg_limit = ACK_POLL_LIMIT_RST;
        cur_fn    = FN_TICK;
        cur_ph    = PH_START_A;
        bit_cnt   = '0;
        dly_cnt   = '0;
        poll_cnt  = '0;
        shifter   = '0;
        scl_q     = 1'b1;
        sda_q     = 1'b1;
        sda_oe    = 1'b1;
        ack_sel   = 1'b0;
        rx_last   = '0;
    endfunction

    function automatic void load_delay(input int unsigned us);
        int unsigned t;
        t = us * cfg_tpu;
        dly_cnt = (t == 0) ? 10'd1 : t[9:0];
    endfunction

    function automatic void finish_cmd(input logic err);
        cur_fn    = FN_TICK;
        cur_ph    = PH_START_A;
        dly_cnt   = '0;
        tick_done = 1'b1;
        tick_err  = err;
    endfunction

    function automatic void enter_phase(input t_phase p);
        cur_ph = p;
        case (p)
            PH_START_A: begin
                sda_oe = 1'b1; sda_q = 1'b1; scl_q = 1'b1; load_delay(4);
            end
            PH_START_B:     begin sda_q = 1'b0; load_delay(4); end
            PH_BIT_SET:     begin sda_q = shifter[7]; load_delay(2); end
            PH_BIT_HIGH:    begin scl_q = 1'b1; load_delay(2); end
            PH_BIT_LOW:     begin scl_q = 1'b0; load_delay(2); end
            PH_ACK_REL:     begin sda_oe = 1'b0; sda_q = 1'b1; load_delay(1); end
            PH_ACK_HIGH:    begin scl_q = 1'b1; load_delay(1); end
            PH_ACK_POLL:    dly_cnt = '0;
            PH_STOP_A: begin
                sda_oe = 1'b1; scl_q = 1'b0; sda_q = 1'b0; load_delay(4);
            end
            PH_STOP_B:      begin scl_q = 1'b1; sda_q = 1'b1; load_delay(4); end
            PH_RD_LOW:      begin scl_q = 1'b0; load_delay(2); end
            PH_RD_HIGH:     begin scl_q = 1'b1; load_delay(1); end
            PH_RD_ACK_SET: begin
                scl_q = 1'b0; sda_oe = 1'b1; sda_q = ~ack_sel; load_delay(2);
            end
            PH_RD_ACK_HIGH: begin scl_q = 1'b1; load_delay(2); end
            default:        dly_cnt = 10'd1;
        endcase
    endfunction

    function automatic void step_phase(input logic sda);
        case (cur_ph)
            PH_START_A:  enter_phase(PH_START_B);
            PH_START_B:  begin scl_q = 1'b0; finish_cmd(1'b0); end
            PH_BIT_SET:  enter_phase(PH_BIT_HIGH);
            PH_BIT_HIGH: enter_phase(PH_BIT_LOW);
            PH_BIT_LOW: begin
                shifter = shifter << 1;
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8) finish_cmd(1'b0);
                else enter_phase(PH_BIT_SET);
            end
            PH_ACK_REL:  enter_phase(PH_ACK_HIGH);
            PH_ACK_HIGH: enter_phase(PH_ACK_POLL);
            PH_ACK_POLL: begin
                if (!sda) begin
                    scl_q = 1'b0;
                    finish_cmd(1'b0);
                end else if (poll_cnt >= cfg_limit) begin
                    enter_phase(PH_STOP_A);
                end else begin
                    poll_cnt = poll_cnt + 8'd1;
                end
            end
            PH_STOP_A:   enter_phase(PH_STOP_B);
            PH_STOP_B:   finish_cmd(cur_fn == FN_ACK);
            PH_RD_LOW:   enter_phase(PH_RD_HIGH);
            PH_RD_HIGH: begin
                shifter = {shifter[6:0], sda};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8) begin
                    rx_last = shifter;
                    enter_phase(PH_RD_ACK_SET);
                end else begin
                    enter_phase(PH_RD_LOW);
                end
            end
            PH_RD_ACK_SET:  enter_phase(PH_RD_ACK_HIGH);
            PH_RD_ACK_HIGH: begin scl_q = 1'b0; finish_cmd(1'b0); end
            default:        finish_cmd(1'b0);
        endcase
    endfunction

    function automatic t_out_item i2c_tick(input t_in_item it);
        t_out_item res;
        tick_done = 1'b0;
        tick_err  = 1'b0;
        if (cur_fn == FN_TICK) begin
            if (it.func >= FN_START && it.func <= FN_READ) begin
                cur_fn   = it.func;
                poll_cnt = '0;
                bit_cnt  = '0;
                case (it.func)
                    FN_START: enter_phase(PH_START_A);
                    FN_STOP:  enter_phase(PH_STOP_A);
                    FN_WRITE: begin
                        shifter = it.tx_byte; sda_oe = 1'b1; scl_q = 1'b0;
                        enter_phase(PH_BIT_SET);
                    end
                    FN_ACK:   enter_phase(PH_ACK_REL);
                    default: begin
                        shifter = '0; ack_sel = it.send_ack; sda_oe = 1'b0;
                        enter_phase(PH_RD_LOW);
                    end
                endcase
            end
        end else if (dly_cnt > 10'd1) begin
            dly_cnt = dly_cnt - 10'd1;
        end else begin
            step_phase(it.sda_in);
        end
        res.scl_level = scl_q;
        res.sda_level = sda_oe ? sda_q : 1'b1;
        res.sda_drive = sda_oe;
        res.busy_res  = (cur_fn != FN_TICK);
        res.done_res  = tick_done;
        res.ack_error = tick_err;
        res.rx_byte   = rx_last;
        return res;
    endfunction

    function automatic int us_ticks(input int us);
        int t;
        t = us * plan_tpu;
        return (t == 0) ? 1 : t;
    endfunction

    // One command followed by ticks that carry it to completion, then a few idle ticks.
    // Read bits and the ack poll level are placed on the ticks where they are sampled.
    task automatic add_cmd(input logic [2:0] fn, input logic [7:0] tx, input logic sack,
                           input logic [7:0] rd_bits, input int n_fail, input bit hit_finish);
        t_in_item it;
        int d1, d2, d4, dur, per_bit, j, q, slack;
        d1 = us_ticks(1);
        d2 = us_ticks(2);
        d4 = us_ticks(4);
        per_bit = d2 + d1;
        case (fn)
            FN_START, FN_STOP: dur = 2 * d4;
            FN_WRITE:          dur = 24 * d2;
            FN_READ:           dur = 8 * per_bit + 2 * d2;
            default: begin
                if (n_fail <= plan_limit) dur = 2 * d1 + 1 + n_fail;
                else dur = 2 * d1 + 1 + plan_limit + 2 * d4;
            end
        endcase
        it.func     = fn;
        it.tx_byte  = tx;
        it.send_ack = sack;
        it.sda_in   = 1'($urandom);
        tick_stream.push_back(it);
        n_planned++;
        for (int k = 1; k <= dur; k++) begin
            if (k == dur && hit_finish) it.func = 3'($urandom_range(FN_START, FN_READ));
            else if ($urandom_range(0, 7) == 0) it.func = 3'($urandom_range(0, 7));
            else it.func = FN_TICK;
            it.tx_byte  = 8'($urandom);
            it.send_ack = 1'($urandom);
            it.sda_in   = 1'($urandom);
            q = k / per_bit;
            j = k - (2 * d1 + 1);
            if (fn == FN_READ && k % per_bit == 0 && q >= 1 && q <= 8) begin
                it.sda_in = rd_bits[8 - q];
            end else if (fn == FN_ACK && j >= 0 && j < n_fail) begin
                it.sda_in = 1'b1;
            end else if (fn == FN_ACK && j == n_fail) begin
                it.sda_in = 1'b0;
            end
            tick_stream.push_back(it);
            n_planned++;
        end
        slack = $urandom_range(0, 3);
        for (int k = 0; k < slack; k++) begin
            case ($urandom_range(0, 2))
                0:       it.func = FN_TICK;
                1:       it.func = FN_SPARE6;
                default: it.func = FN_SPARE7;
            endcase
            it.tx_byte  = 8'($urandom);
            it.send_ack = 1'($urandom);
            it.sda_in   = 1'($urandom);
            tick_stream.push_back(it);
            n_planned++;
        end
    endtask

    task automatic drain_bus();
        while (tick_stream.size() != 0 || in_valid || bus_ticks_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_bus_config(input logic [7:0] tpu, input logic [7:0] limit);
        drain_bus();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_TICKS_PER_US;
        cfg_data <= tpu;
        @(posedge clk);
        cfg_idx  <= REG_ACK_POLL_LIMIT;
        cfg_data <= limit;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cfg_tpu    = tpu;
        cfg_limit  = limit;
        plan_tpu   = tpu;
        plan_limit = limit;
    endtask

    task automatic run_phase(input logic [7:0] tpu, input logic [7:0] limit, input int budget);
        int base, n_fail, few;
        set_bus_config(tpu, limit);
        base = n_planned;
        few = (plan_limit < 4) ? plan_limit : 4;
        while (n_planned - base < budget) begin
            case ($urandom_range(0, 3))
                0:       n_fail = plan_limit + 1;
                1:       n_fail = $urandom_range(0, plan_limit);
                default: n_fail = $urandom_range(0, few);
            endcase
            add_cmd(3'($urandom_range(FN_START, FN_READ)), 8'($urandom), 1'($urandom),
                    8'($urandom), n_fail, $urandom_range(0, 3) == 0);
        end
        drain_bus();
    endtask

    task automatic note_mismatch(input string what);
        n_mismatch++;
        if (n_mismatch <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            note_mismatch($sformatf("result %0d %s got %0h want %0h",
                                    n_results, name, got, want));
    endtask

    // sender: bursts and gaps, payload held while stalled
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                bus_ticks_due.push_back(i2c_tick(in_data));
            end
            if (!(in_valid && in_stall)) begin
                if (gap_left > 0) begin
                    in_valid <= 1'b0;
                    gap_left--;
                end else if (tick_stream.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data  <= tick_stream.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 60);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern, plus one long hold-off to back up the input
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (hold_left == 0 && !long_hold_done && n_results >= 600 &&
                tick_stream.size() > 50) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(16, 128);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            n_results++;
            if (bus_ticks_due.size() == 0) begin
                note_mismatch($sformatf("result %0d with no transaction outstanding",
                                        n_results));
            end else begin
                want = bus_ticks_due.pop_front();
                check_field("scl_level", 8'(out_data.scl_level), 8'(want.scl_level));
                check_field("sda_level", 8'(out_data.sda_level), 8'(want.sda_level));
                check_field("sda_drive", 8'(out_data.sda_drive), 8'(want.sda_drive));
                check_field("busy_res",  8'(out_data.busy_res),  8'(want.busy_res));
                check_field("done_res",  8'(out_data.done_res),  8'(want.done_res));
                check_field("ack_error", 8'(out_data.ack_error), 8'(want.ack_error));
                check_field("rx_byte",   out_data.rx_byte,       want.rx_byte);
            end
        end
    end

    initial begin
        reset_engine();
        plan_tpu   = TICKS_PER_US_RST;
        plan_limit = ACK_POLL_LIMIT_RST;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset timing
        add_cmd(FN_START, 8'h00, 1'b0, 8'h00, 0, 1'b0);
        add_cmd(FN_WRITE, 8'hA5, 1'b0, 8'h00, 0, 1'b0);
        add_cmd(FN_ACK,   8'h00, 1'b0, 8'h00, 3, 1'b0);
        add_cmd(FN_READ,  8'h00, 1'b1, 8'h5A, 0, 1'b0);
        add_cmd(FN_STOP,  8'h00, 1'b0, 8'h00, 0, 1'b0);

        // zero delay and zero poll allowance
        set_bus_config(8'd0, 8'd0);
        tick_stream.push_back(t_in_item'{func: FN_SPARE6, tx_byte: 8'hFF,
                                         send_ack: 1'b1, sda_in: 1'b1});
        tick_stream.push_back(t_in_item'{func: FN_SPARE7, tx_byte: 8'h00,
                                         send_ack: 1'b0, sda_in: 1'b0});
        n_planned += 2;
        add_cmd(FN_START, 8'h00, 1'b0, 8'h00, 0, 1'b0);
        add_cmd(FN_WRITE, 8'h00, 1'b0, 8'h00, 0, 1'b0);
        add_cmd(FN_WRITE, 8'hFF, 1'b1, 8'h00, 0, 1'b1);
        add_cmd(FN_ACK,   8'h00, 1'b0, 8'h00, 0, 1'b0);
        add_cmd(FN_ACK,   8'h00, 1'b0, 8'h00, 1, 1'b0);
        add_cmd(FN_READ,  8'h00, 1'b1, 8'hFF, 0, 1'b0);
        add_cmd(FN_READ,  8'hFF, 1'b0, 8'h00, 0, 1'b1);
        add_cmd(FN_STOP,  8'h00, 1'b0, 8'h00, 0, 1'b0);

        run_phase(8'd1,   8'd1,   300);
        run_phase(8'd2,   8'd255, 300);
        run_phase(8'd3,   8'd4,   300);
        run_phase(8'd0,   8'd2,   300);
        run_phase(8'd1,   8'd250, 300);

        // slowest bus timing: a short sequence only
        set_bus_config(8'd255, 8'd2);
        add_cmd(FN_START, 8'h00, 1'b0, 8'h00, 0, 1'b0);
        add_cmd(FN_ACK,   8'h00, 1'b0, 8'h00, 3, 1'b0);
        add_cmd(FN_STOP,  8'h00, 1'b0, 8'h00, 0, 1'b1);

        drain_bus();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (n_mismatch == 0 && bus_ticks_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
rtl/i2cm_pkg.sv
rtl/i2cm_engine.sv
rtl/i2c_bitbang_master.sv
tb/testbench.sv
